@@ sv/overwriting_entry_ring_with_offset_find_unit_macros.svh @@
// Assertion macros used by the ring unit datapath (oerf_datapath).
// Both expect a clock named clock and a reset named reset in scope.
`ifndef OVERWRITING_ENTRY_RING_WITH_OFFSET_FIND_UNIT_MACROS_SVH
`define OVERWRITING_ENTRY_RING_WITH_OFFSET_FIND_UNIT_MACROS_SVH

// same-cycle implication
`define OERF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ring unit check failed");

// next-cycle implication
`define OERF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ring unit check failed");

`endif

@@ sv/oerf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package oerf_pkg;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_FIND = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] entry_handle;
      logic [15:0] entry_size;
      logic [19:0] stream_index;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  found_slot;
      logic [31:0] found_handle;
      logic [15:0] byte_in_entry;
      logic        evicted;
      logic [31:0] evicted_handle;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ADD,
      ST_CHECK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic do_add;
      logic do_check;
      logic rsp_valid;
      logic req_stall;
   } cmd_type;

   typedef struct packed {
      logic is_find;
      logic walk_done;
   } status_type;

endpackage

`default_nettype wire

@@ sv/overwriting_entry_ring_with_offset_find_unit.sv @@
// channel | ports                          | moves
// --------+--------------------------------+---------------------------------
// request | req_valid, req_stall, req_word | add entry or find char offset
// result  | rsp_valid, rsp_stall, rsp_word | find hit / eviction report
//
// An add passes through the read, add and result states after accept; a
// find walks at most DEPTH entries, one entry memory read then one compare
// per entry over the single read port. The unit then returns to idle.
// Reset empties the ring through per-entry valid bits.
// req_stall goes high after accept and stays high until the result word is taken;
// a stalled result holds in its register.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_entry_ring_with_offset_find_unit #(
   parameter int DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  oerf_pkg::req_type req_word,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output oerf_pkg::rsp_type rsp_word
);
   import oerf_pkg::*;

   cmd_type    cmd;
   status_type status;

   oerf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   oerf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

   assign req_stall = cmd.req_stall;
   assign rsp_valid = cmd.rsp_valid;

endmodule

`default_nettype wire

@@ sv/oerf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module oerf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  rsp_stall,
   input  oerf_pkg::status_type status,
   output oerf_pkg::cmd_type    cmd
);
   import oerf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = status.is_find ? ST_CHECK : ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_RESP;
         end
         ST_CHECK: begin
            state_in = status.walk_done ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_stall = 1'b0;
            cmd.latch_req = req_valid;
         end
         ST_READ: begin
         end
         ST_ADD: begin
            cmd.do_add = 1'b1;
         end
         ST_CHECK: begin
            cmd.do_check = 1'b1;
         end
         ST_RESP: begin
            cmd.rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/oerf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "overwriting_entry_ring_with_offset_find_unit_macros.svh"

module oerf_datapath #(
   parameter int DEPTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  oerf_pkg::req_type    req_word,
   input  oerf_pkg::cmd_type    cmd,
   output oerf_pkg::status_type status,
   output oerf_pkg::rsp_type    rsp_word
);
   import oerf_pkg::*;

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W  = (SLOT_W + 17 > 20) ? SLOT_W + 17 : 20;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   // entry store; valid bits stand in for the reset clear
   logic [31:0] mem_handle [DEPTH];
   logic [15:0] mem_size   [DEPTH];
   logic [DEPTH-1:0] valid_ff;

   logic [SLOT_W-1:0] write_slot_ff, read_slot_ff, walk_ff, count_ff;
   logic              full_ff;
   logic [CMP_W-1:0]  total_ff;
   req_type           req_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [31:0] rd_handle_ff;
   logic [15:0] rd_size_ff;
   logic        rd_valid_ff;

   always_ff @(posedge clock) begin
      rd_handle_ff <= mem_handle[walk_ff];
      rd_size_ff   <= mem_size[walk_ff];
      if (cmd.do_add) begin
         mem_handle[write_slot_ff] <= req_ff.entry_handle;
         mem_size[write_slot_ff]   <= req_ff.entry_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[walk_ff];
      end
   end

   // entry seen by the walk, reset value when never written
   logic [31:0]      cur_handle;
   logic [15:0]      cur_size;
   logic [CMP_W-1:0] end_pos;
   logic [CMP_W-1:0] offset_ext;
   logic [CMP_W-1:0] delta;
   logic             empty, hit, stop;
   logic [SLOT_W-1:0] walk_next;
   logic [SLOT_W-1:0] write_next, read_next;

   always_comb begin
      cur_handle = rd_valid_ff ? rd_handle_ff : '0;
      cur_size   = rd_valid_ff ? rd_size_ff : '0;
      offset_ext = CMP_W'(req_ff.stream_index);
      end_pos    = total_ff + CMP_W'(cur_size);
      delta      = offset_ext - total_ff;
      empty      = (cur_handle == '0) || (cur_size == '0);
      hit        = !empty && (offset_ext < end_pos);
      walk_next  = next_slot(walk_ff);
      stop       = ((walk_next == write_slot_ff) && !full_ff) || (count_ff == LAST_SLOT);
      write_next = next_slot(write_slot_ff);
      read_next  = next_slot(read_slot_ff);
   end

   assign status.is_find   = (req_ff.operation == OP_FIND);
   assign status.walk_done = empty || hit || stop;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         full_ff       <= 1'b0;
         walk_ff       <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
      end else begin
         if (cmd.latch_req) begin
            walk_ff  <= read_slot_ff;
            count_ff <= '0;
            total_ff <= '0;
         end
         if (cmd.do_add) begin
            valid_ff[write_slot_ff] <= 1'b1;
            write_slot_ff <= write_next;
            if (full_ff) begin
               read_slot_ff <= read_next;
               full_ff      <= (write_next == read_next);
            end else begin
               full_ff <= (write_next == read_slot_ff);
            end
         end
         if (cmd.do_check && !(empty || hit || stop)) begin
            walk_ff  <= walk_next;
            count_ff <= count_ff + 1'b1;
            total_ff <= end_pos;
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.do_add) begin
         rsp_in                = '0;
         rsp_in.evicted        = full_ff;
         rsp_in.evicted_handle = full_ff ? cur_handle : '0;
      end else if (cmd.do_check && status.walk_done) begin
         rsp_in = '0;
         if (hit) begin
            rsp_in.found         = 1'b1;
            rsp_in.found_slot    = 4'(walk_ff);
            rsp_in.found_handle  = cur_handle;
            rsp_in.byte_in_entry = delta[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_word = rsp_ff;

   `OERF_ASSERT_NOW(a_full_pointers_meet, full_ff, write_slot_ff == read_slot_ff)
   `OERF_ASSERT_NOW(a_add_rsp_no_find, cmd.rsp_valid && !status.is_find, !rsp_ff.found)
   `OERF_ASSERT_NEXT(a_find_keeps_ptrs, cmd.do_check,
                     $stable(write_slot_ff) && $stable(read_slot_ff))
   `OERF_ASSERT_NEXT(a_add_nonfull_keeps_read, cmd.do_add && !full_ff, $stable(read_slot_ff))

endmodule

`default_nettype wire

@@ tb/overwriting_entry_ring_with_offset_find_unit_tb.sv @@
`timescale 1ns / 1ps

module overwriting_entry_ring_with_offset_find_unit_tb;
   import oerf_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_WORDS = 1370;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam rsp_type NO_RESULT = '0;

   typedef struct packed {
      logic        op;
      logic [31:0] handle;
      logic [15:0] size;
      logic [19:0] offset;
      logic [7:0]  reps;
      logic        typed;
      rsp_type     want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   // shadow copy of the ring
   logic [31:0] ring_handle [DEPTH];
   logic [15:0] ring_size [DEPTH];
   int          wr_slot;
   int          rd_slot;
   bit          is_full;

   rsp_type      awaited_rsp [$];
   plan_row_type plan [0:18];
   int           errors = 0;
   int           quiet_items = 0;
   int           stall_left = 0;
   int           stall_pick;
   int           idle_cycles;

   overwriting_entry_ring_with_offset_find_unit #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type hit(int slot, logic [31:0] handle, logic [15:0] pos);
      rsp_type r;
      r = '0;
      r.found = 1'b1;
      r.found_slot = slot[3:0];
      r.found_handle = handle;
      r.byte_in_entry = pos;
      return r;
   endfunction

   function automatic rsp_type evict(logic [31:0] handle);
      rsp_type r;
      r = '0;
      r.evicted = 1'b1;
      r.evicted_handle = handle;
      return r;
   endfunction

   // updates the shadow ring and returns the word the block should answer with
   function automatic rsp_type ring_apply(req_type w);
      rsp_type     r;
      int          slot;
      int unsigned total;
      r = '0;
      if (w.operation == OP_ADD) begin
         if (is_full) begin
            r.evicted = 1'b1;
            r.evicted_handle = ring_handle[rd_slot];
            rd_slot = (rd_slot + 1) % DEPTH;
         end
         ring_handle[wr_slot] = w.entry_handle;
         ring_size[wr_slot] = w.entry_size;
         wr_slot = (wr_slot + 1) % DEPTH;
         is_full = (wr_slot == rd_slot);
      end else begin
         total = 0;
         slot = rd_slot;
         for (int n = 0; n < DEPTH; n++) begin
            if (ring_handle[slot] == 0 || ring_size[slot] == 0) break;
            if (w.stream_index < total + ring_size[slot]) begin
               r = hit(slot, ring_handle[slot], 16'(w.stream_index - total));
               break;
            end
            total += ring_size[slot];
            slot = (slot + 1) % DEPTH;
            if (slot == wr_slot && !is_full) break;
         end
      end
      return r;
   endfunction

   function automatic int unsigned stored_bytes();
      int unsigned sum;
      sum = 0;
      for (int n = 0; n < DEPTH; n++) sum += ring_size[n];
      return sum;
   endfunction

   // mostly back-to-back or short gaps, a few long ones, and quiet stretches
   function automatic int pick_gap();
      int k;
      if (quiet_items > 0) begin
         quiet_items--;
         return 0;
      end
      k = $urandom_range(0, 99);
      if (k < 5) begin
         quiet_items = $urandom_range(20, 80);
         return 0;
      end
      if (k < 55) return 0;
      if (k < 88) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type random_word();
      req_type     w;
      int          k;
      int unsigned span;
      w.operation = ($urandom_range(0, 99) < 35) ? OP_ADD : OP_FIND;
      w.entry_handle = ($urandom_range(0, 99) < 3) ? 32'h0 : 32'($urandom());
      k = $urandom_range(0, 99);
      if (k < 3) w.entry_size = 16'h0;
      else if (k < 70) w.entry_size = 16'($urandom_range(1, 64));
      else if (k < 90) w.entry_size = 16'($urandom_range(65, 4096));
      else w.entry_size = 16'($urandom_range(0, 65535));
      // offsets mostly land inside or just past the stored stream
      span = stored_bytes() + 4;
      if (span > 20'hFFFFF) span = 20'hFFFFF;
      if ($urandom_range(0, 99) < 80) w.stream_index = 20'($urandom_range(0, span));
      else w.stream_index = 20'($urandom());
      return w;
   endfunction

   task automatic report(string msg);
      $display("tb: %s", msg);
      errors++;
   endtask

   task automatic send_word(req_type w, bit typed, rsp_type typed_rsp);
      int      gap;
      rsp_type p;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = ring_apply(w);
      awaited_rsp.push_back(typed ? typed_rsp : p);
   endtask

   // result side: random stall, check every accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            report($sformatf("result word %h with nothing pending", rsp_word));
         end else begin
            rsp_type want;
            want = awaited_rsp.pop_front();
            if (rsp_word.found !== want.found)
               report($sformatf("found got %h want %h", rsp_word.found, want.found));
            if (rsp_word.found_slot !== want.found_slot)
               report($sformatf("found_slot got %h want %h",
                                rsp_word.found_slot, want.found_slot));
            if (rsp_word.found_handle !== want.found_handle)
               report($sformatf("found_handle got %h want %h",
                                rsp_word.found_handle, want.found_handle));
            if (rsp_word.byte_in_entry !== want.byte_in_entry)
               report($sformatf("byte_in_entry got %h want %h",
                                rsp_word.byte_in_entry, want.byte_in_entry));
            if (rsp_word.evicted !== want.evicted)
               report($sformatf("evicted got %h want %h", rsp_word.evicted, want.evicted));
            if (rsp_word.evicted_handle !== want.evicted_handle)
               report($sformatf("evicted_handle got %h want %h",
                                rsp_word.evicted_handle, want.evicted_handle));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 55) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(0, 8);
         end else if (stall_pick < 65) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(30, 120);
         end else if (stall_pick < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_type w;
      for (int n = 0; n < DEPTH; n++) begin
         ring_handle[n] = '0;
         ring_size[n] = '0;
      end
      wr_slot = 0;
      rd_slot = 0;
      is_full = 1'b0;

      // empty ring, empty entry at the oldest slot, fill, then overwrite
      plan[0]  = '{OP_FIND, 32'h0, 16'h0, 20'h0, 8'd1, 1'b1, NO_RESULT};
      plan[1]  = '{OP_FIND, 32'h0, 16'h0, 20'hFFFFF, 8'd1, 1'b1, NO_RESULT};
      plan[2]  = '{OP_ADD, 32'h0, 16'd9, 20'h0, 8'd1, 1'b1, NO_RESULT};
      plan[3]  = '{OP_FIND, 32'h0, 16'h0, 20'h0, 8'd1, 1'b1, NO_RESULT};
      plan[4]  = '{OP_ADD, 32'hFFFFFFFF, 16'hFFFF, 20'h0, 8'd1, 1'b1, NO_RESULT};
      plan[5]  = '{OP_ADD, 32'h1, 16'h0, 20'h0, 8'd1, 1'b1, NO_RESULT};
      plan[6]  = '{OP_ADD, 32'h100, 16'd3, 20'h0, 8'd13, 1'b1, NO_RESULT};
      plan[7]  = '{OP_FIND, 32'h0, 16'h0, 20'h0, 8'd1, 1'b1, NO_RESULT};
      plan[8]  = '{OP_ADD, 32'h200, 16'hFFFF, 20'h0, 8'd1, 1'b1, evict(32'h0)};
      plan[9]  = '{OP_FIND, 32'h0, 16'h0, 20'h0, 8'd1, 1'b1, hit(1, 32'hFFFFFFFF, 16'h0)};
      plan[10] = '{OP_FIND, 32'h0, 16'h0, 20'hFFFF, 8'd1, 1'b0, NO_RESULT};
      plan[11] = '{OP_ADD, 32'h300, 16'd2, 20'h0, 8'd1, 1'b1, evict(32'hFFFFFFFF)};
      plan[12] = '{OP_FIND, 32'h0, 16'h0, 20'h0, 8'd1, 1'b0, NO_RESULT};
      plan[13] = '{OP_ADD, 32'h400, 16'd4, 20'h0, 8'd1, 1'b1, evict(32'h1)};
      plan[14] = '{OP_FIND, 32'h0, 16'h0, 20'h0, 8'd1, 1'b0, NO_RESULT};
      plan[15] = '{OP_FIND, 32'h0, 16'h0, 20'd38, 8'd1, 1'b0, NO_RESULT};
      plan[16] = '{OP_FIND, 32'h0, 16'h0, 20'd39, 8'd1, 1'b0, NO_RESULT};
      plan[17] = '{OP_FIND, 32'h0, 16'h0, 20'hFFFFF, 8'd1, 1'b0, NO_RESULT};
      plan[18] = '{OP_FIND, 32'h0, 16'h0, 20'd65579, 8'd1, 1'b0, NO_RESULT};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (int r = 0; r < plan[i].reps; r++) begin
            w.operation = plan[i].op;
            w.entry_handle = plan[i].handle + r;
            w.entry_size = plan[i].size;
            w.stream_index = plan[i].offset;
            send_word(w, plan[i].typed, plan[i].want);
         end
      end

      for (int n = 0; n < RANDOM_WORDS; n++) send_word(random_word(), 1'b0, NO_RESULT);
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

@@ overwriting_entry_ring_with_offset_find_unit.f @@
+incdir+sv
sv/oerf_pkg.sv
sv/oerf_ctrl.sv
sv/oerf_datapath.sv
sv/overwriting_entry_ring_with_offset_find_unit.sv
tb/overwriting_entry_ring_with_offset_find_unit_tb.sv
